// File: hdl/gla_pkg.sv
// Shared types for the gate layer assigner.
package gla_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_PROBE,
    S_WRITE
  } gla_state_t;

endpackage

// File: hdl/gate_layer_assigner_top.sv
// Gate layer assigner: earliest-layer placement of gates over a qubit occupancy map.
//
//  channel   | handshake         | fields
//  ----------+-------------------+----------------------------------------------
//  request   | start, busy       | qubit_a, qubit_b, qubit_c, operand_count
//  result    | valid (1 cycle)   | layer, overflow
//
// A request reads its operands in S_READ, probes occupancy rows in S_PROBE and
// writes the operands in S_WRITE; the result strobe follows in the next cycle.
// Qubit layer reads and writes share one port of the per-qubit memory, one
// operand a cycle, and the occupancy memory is probed one row a cycle. A rejected
// operand index is answered from S_IDLE, strobe in the next cycle. After reset the
// occupancy memory is cleared one row a cycle while busy. The receiver cannot stall.
module gate_layer_assigner_top #(
  parameter int NUM_QUBITS = 64,
  parameter int NUM_LAYERS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] qubit_a,
  input  logic [5:0] qubit_b,
  input  logic [5:0] qubit_c,
  input  logic [1:0] operand_count,
  output logic       valid,
  output logic [7:0] layer,
  output logic       overflow
);
  import gla_pkg::*;

  localparam int QW = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;
  localparam int AW = $clog2(NUM_LAYERS);
  localparam int LW = $clog2(NUM_LAYERS + 1);
  localparam logic [LW-1:0] LAST_PLUS1 = LW'(NUM_LAYERS);
  localparam logic [AW-1:0] LAST_ROW   = AW'(NUM_LAYERS - 1);

  gla_state_t state, state_next;

  // latched request
  logic [5:0]            q0, q1, q2;
  logic [1:0]            cnt;
  logic [NUM_QUBITS-1:0] guard;
  logic [NUM_QUBITS-1:0] opmask;
  logic [LW-1:0]         layer_q;
  logic [1:0]            idx;
  logic [AW-1:0]         clr_addr;

  // memories
  logic [LW-1:0]         qmem [NUM_QUBITS];
  logic [NUM_QUBITS-1:0] qvalid;
  logic [LW-1:0]         q_rd_data;
  logic                  q_rd_vld;
  logic [NUM_QUBITS-1:0] omem [NUM_LAYERS];
  logic [NUM_QUBITS-1:0] o_rd_data;

  // memory controls
  logic                  q_rd_en, q_wr_en, o_rd_en, o_wr_en;
  logic [QW-1:0]         q_rd_addr, q_wr_addr;
  logic [AW-1:0]         o_rd_addr, o_wr_addr;
  logic [NUM_QUBITS-1:0] o_wr_data;

  // request decode
  logic                  accept;
  logic [1:0]            in_cnt;
  logic                  in_bad;
  logic [NUM_QUBITS-1:0] in_guard, in_opmask;

  // control
  logic [5:0]    qsel;
  logic [LW-1:0] rd_layer, layer_max, layer_inc;
  logic          emit, emit_ovf;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_cnt = (operand_count == 2'd0) ? 2'd1 : operand_count;

  always_comb begin
    logic [5:0] lo01, hi01, lo02, hi02, lo12, hi12;
    logic [6:0] ii;
    lo01 = (qubit_a < qubit_b) ? qubit_a : qubit_b;
    hi01 = (qubit_a < qubit_b) ? qubit_b : qubit_a;
    lo02 = (qubit_a < qubit_c) ? qubit_a : qubit_c;
    hi02 = (qubit_a < qubit_c) ? qubit_c : qubit_a;
    lo12 = (qubit_b < qubit_c) ? qubit_b : qubit_c;
    hi12 = (qubit_b < qubit_c) ? qubit_c : qubit_b;
    in_bad = ({1'b0, qubit_a} >= 7'(NUM_QUBITS))
          || (in_cnt >= 2'd2 && {1'b0, qubit_b} >= 7'(NUM_QUBITS))
          || (in_cnt == 2'd3 && {1'b0, qubit_c} >= 7'(NUM_QUBITS));
    for (int i = 0; i < NUM_QUBITS; i++) begin
      ii = 7'(i);
      in_guard[i] =
          (in_cnt >= 2'd2 && ii > {1'b0, lo01} && ii < {1'b0, hi01})
       || (in_cnt == 2'd3 && ii > {1'b0, lo02} && ii < {1'b0, hi02})
       || (in_cnt == 2'd3 && ii > {1'b0, lo12} && ii < {1'b0, hi12});
      in_opmask[i] = (ii == {1'b0, qubit_a})
       || (in_cnt >= 2'd2 && ii == {1'b0, qubit_b})
       || (in_cnt == 2'd3 && ii == {1'b0, qubit_c});
    end
  end

  always_comb begin
    case (idx)
      2'd0:    qsel = q0;
      2'd1:    qsel = q1;
      default: qsel = q2;
    endcase
  end

  assign rd_layer  = q_rd_vld ? q_rd_data : '0;
  assign layer_max = (rd_layer > layer_q) ? rd_layer : layer_q;
  assign layer_inc = LW'(layer_q + 1'b1);

  // next state and memory controls
  always_comb begin
    state_next = state;
    q_rd_en    = 1'b0;
    q_rd_addr  = qsel[QW-1:0];
    q_wr_en    = 1'b0;
    q_wr_addr  = qsel[QW-1:0];
    o_rd_en    = 1'b0;
    o_rd_addr  = layer_q[AW-1:0];
    o_wr_en    = 1'b0;
    o_wr_addr  = layer_q[AW-1:0];
    o_wr_data  = o_rd_data | opmask;
    emit       = 1'b0;
    emit_ovf   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        o_wr_en   = 1'b1;
        o_wr_addr = clr_addr;
        o_wr_data = '0;
        if (clr_addr == LAST_ROW) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            emit     = 1'b1;
            emit_ovf = 1'b1;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        // issue one operand read per cycle, fold the previous one into the max
        if (idx < cnt) begin
          q_rd_en = 1'b1;
        end else if (layer_max >= LAST_PLUS1) begin
          emit       = 1'b1;
          emit_ovf   = 1'b1;
          state_next = S_IDLE;
        end else begin
          o_rd_en    = 1'b1;
          o_rd_addr  = layer_max[AW-1:0];
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if ((o_rd_data & guard) != '0) begin
          if (layer_inc >= LAST_PLUS1) begin
            emit       = 1'b1;
            emit_ovf   = 1'b1;
            state_next = S_IDLE;
          end else begin
            o_rd_en   = 1'b1;
            o_rd_addr = layer_inc[AW-1:0];
          end
        end else begin
          o_wr_en    = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        q_wr_en = 1'b1;
        if (idx == 2'(cnt - 2'd1)) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      valid    <= 1'b0;
    end else begin
      valid <= emit;
      if (state == S_CLEAR) clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  // result and request registers
  always_ff @(posedge clk) begin
    if (emit) begin
      overflow <= emit_ovf;
      layer    <= emit_ovf ? 8'd0 : 8'(layer_q);
    end
    case (state)
      S_IDLE: begin
        q0      <= qubit_a;
        q1      <= qubit_b;
        q2      <= qubit_c;
        cnt     <= in_cnt;
        guard   <= in_guard;
        opmask  <= in_opmask;
        idx     <= '0;
        layer_q <= '0;
      end
      S_READ: begin
        if (idx != 2'd0) layer_q <= layer_max;
        if (idx < cnt) idx <= 2'(idx + 2'd1);
        else idx <= '0;
      end
      S_PROBE: begin
        if ((o_rd_data & guard) != '0) layer_q <= layer_inc;
        idx <= '0;
      end
      S_WRITE: idx <= 2'(idx + 2'd1);
      default: idx <= '0;
    endcase
  end

  // per-qubit next-layer memory; entries never written read as zero
  always_ff @(posedge clk) begin
    if (q_rd_en) q_rd_data <= qmem[q_rd_addr];
    if (q_wr_en) qmem[q_wr_addr] <= layer_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid   <= '0;
      q_rd_vld <= 1'b0;
    end else begin
      if (q_rd_en) q_rd_vld <= qvalid[q_rd_addr];
      if (q_wr_en) qvalid[q_wr_addr] <= 1'b1;
    end
  end

  // occupancy memory
  always_ff @(posedge clk) begin
    if (o_rd_en) o_rd_data <= omem[o_rd_addr];
    if (o_wr_en) omem[o_wr_addr] <= o_wr_data;
  end

  a_ovf_layer_zero: assert property (@(posedge clk) disable iff (rst)
    valid && overflow |-> layer == 8'd0)
    else $error("overflow result carries a nonzero layer");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result strobe while a request is in flight");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> layer_q < LAST_PLUS1)
    else $error("probe beyond the last layer");

  a_write_index: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> idx < cnt)
    else $error("qubit write past the operand count");

endmodule
